/* hw/rtl/mhnr_pkg.sv */
// ----------------------------------------------------------------------------
// mhnr_pkg
// Types and constants shared by the held-note retrigger block.
// ----------------------------------------------------------------------------
package mhnr_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int DIVISOR_W   = 16;

    localparam logic [3:0]            KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0]            KIND_NOTE_OFF = 4'h8;
    localparam logic [BYTE_W-1:0]     STATUS_CLOCK  = 8'hF8;
    localparam logic [COUNT_W-1:0]    COUNT_FULL    = 2'd3;
    localparam logic [COUNT_W-1:0]    COUNT_NONE    = 2'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GATE_LENGTH = 1'b1;

    localparam logic [CFG_DATA_W-1:0] TICK_PERIOD_RESET = 16'd6;
    localparam logic [CFG_DATA_W-1:0] GATE_LENGTH_RESET = 16'd3;

    typedef struct packed {
        logic [3:0]        channel;
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] velocity;
    } slot_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

/* hw/rtl/mhnr_msg_if.sv */
// ----------------------------------------------------------------------------
// mhnr_msg_if
// Incoming MIDI message channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhnr_msg_if;

    logic                          valid;
    logic                          ready;
    logic [mhnr_pkg::BYTE_W-1:0]   status_byte;
    logic [mhnr_pkg::BYTE_W-1:0]   first_data;
    logic [mhnr_pkg::BYTE_W-1:0]   second_data;
    logic [mhnr_pkg::COUNT_W-1:0]  byte_count;

    modport source (output valid, status_byte, first_data, second_data, byte_count,
                    input ready);
    modport sink   (input valid, status_byte, first_data, second_data, byte_count,
                    output ready);

endinterface

/* hw/rtl/mhnr_result_if.sv */
// ----------------------------------------------------------------------------
// mhnr_result_if
// Outgoing MIDI message channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhnr_result_if;

    logic                          valid;
    logic                          ready;
    logic [mhnr_pkg::BYTE_W-1:0]   out_status;
    logic [mhnr_pkg::BYTE_W-1:0]   out_first;
    logic [mhnr_pkg::BYTE_W-1:0]   out_second;
    logic [mhnr_pkg::COUNT_W-1:0]  out_count;
    logic                          last_of_run;

    modport source (output valid, out_status, out_first, out_second, out_count,
                    last_of_run, input ready);
    modport sink   (input valid, out_status, out_first, out_second, out_count,
                    last_of_run, output ready);

endinterface

/* hw/rtl/mhnr_cfg_if.sv */
// ----------------------------------------------------------------------------
// mhnr_cfg_if
// Configuration register write channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhnr_cfg_if;

    logic                              valid;
    logic                              ready;
    logic [mhnr_pkg::CFG_INDEX_W-1:0]  index;
    logic [mhnr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

/* hw/rtl/midi_held_note_retrigger_top.sv */
// ----------------------------------------------------------------------------
// midi_held_note_retrigger_top
// Held-note table with clock-driven retrigger of note-ons and note-offs.
// ----------------------------------------------------------------------------
// note-on and note-off: a slot-a-cycle walk of the table, then an insert step for a note-on; no result
// pass-through: full messages other than notes, result registered from S_LAST; short non-clock ones dropped
// clock message: the bit-serial remainder unit (skipped when tick_period is zero), up to
//   two slot walks and then the clock itself in the output register, plus output stalls
// one message at a time; ready is low until the message is done and any result is in the output register
// reset: table empty, counters zero, tick_period 6, gate_length 3
module midi_held_note_retrigger_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNTER_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    mhnr_cfg_if.sink      cfg,
    mhnr_msg_if.sink      message,
    mhnr_result_if.source result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HC_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int BW    = mhnr_pkg::BYTE_W;
    localparam int CW    = mhnr_pkg::COUNT_W;
    localparam int DW    = mhnr_pkg::CFG_DATA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_INSERT,
        S_DIV,
        S_GATE,
        S_ON_WALK,
        S_OFF_WALK,
        S_LAST
    } state_t;

    state_t                    state_reg;
    logic [DW-1:0]             tick_period_reg;
    logic [DW-1:0]             gate_length_reg;
    mhnr_pkg::slot_t           slots_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  valid_reg;
    logic [HC_W-1:0]           held_count_reg;
    logic [COUNTER_BITS-1:0]   clock_count_reg;
    logic [COUNTER_BITS-1:0]   retrigger_time_reg;

    logic [BW-1:0]             status_reg;
    logic [BW-1:0]             first_reg;
    logic [BW-1:0]             second_reg;
    logic [CW-1:0]             count_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          free_idx_reg;
    logic                      free_found_reg;
    logic                      found_reg;
    logic                      retrig_reg;
    logic                      off_reg;

    logic                      out_valid_reg;
    logic [BW-1:0]             out_status_reg;
    logic [BW-1:0]             out_first_reg;
    logic [BW-1:0]             out_second_reg;
    logic [CW-1:0]             out_count_reg;
    logic                      out_last_reg;

    logic                      out_free;
    logic                      is_clock;
    logic                      last_idx;
    logic                      slot_match;
    logic                      do_insert;
    logic [HC_W-1:0]           count_after_insert;
    logic [COUNTER_BITS-1:0]   elapsed;
    logic                      rem_start;
    mhnr_pkg::rem_status_t     rem_status;
    mhnr_pkg::slot_t           cur_slot;

    assign out_free  = !out_valid_reg || result.ready;
    assign is_clock  = (status_reg == mhnr_pkg::STATUS_CLOCK);
    assign last_idx  = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign cur_slot  = slots_reg[idx_reg];
    assign slot_match = valid_reg[idx_reg]
                        && (cur_slot.channel == status_reg[3:0])
                        && (cur_slot.note == first_reg);
    assign do_insert = !found_reg && free_found_reg;
    assign count_after_insert = held_count_reg + HC_W'(do_insert);
    assign elapsed   = clock_count_reg - retrigger_time_reg;
    assign rem_start = (state_reg == S_DECODE) && (count_reg != mhnr_pkg::COUNT_NONE)
                       && is_clock && (tick_period_reg != '0);

    mhnr_rem_unit #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (clock_count_reg),
        .divisor  (tick_period_reg),
        .status   (rem_status)
    );

    // slot payload, written on insert only
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INSERT && do_insert)
        begin
            slots_reg[free_idx_reg] <= '{channel:  status_reg[3:0],
                                         note:     first_reg,
                                         velocity: second_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            tick_period_reg    <= mhnr_pkg::TICK_PERIOD_RESET;
            gate_length_reg    <= mhnr_pkg::GATE_LENGTH_RESET;
            valid_reg          <= '0;
            held_count_reg     <= '0;
            clock_count_reg    <= '0;
            retrigger_time_reg <= '0;
            status_reg         <= '0;
            first_reg          <= '0;
            second_reg         <= '0;
            count_reg          <= '0;
            idx_reg            <= '0;
            free_idx_reg       <= '0;
            free_found_reg     <= 1'b0;
            found_reg          <= 1'b0;
            retrig_reg         <= 1'b0;
            off_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_status_reg     <= '0;
            out_first_reg      <= '0;
            out_second_reg     <= '0;
            out_count_reg      <= '0;
            out_last_reg       <= 1'b0;
        end
        else
        begin
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    mhnr_pkg::CFG_TICK_PERIOD: tick_period_reg <= cfg.data;
                    mhnr_pkg::CFG_GATE_LENGTH: gate_length_reg <= cfg.data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (message.valid)
                    begin
                        status_reg <= message.status_byte;
                        first_reg  <= message.first_data;
                        second_reg <= message.second_data;
                        count_reg  <= message.byte_count;
                        state_reg  <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    idx_reg        <= '0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                    retrig_reg     <= 1'b0;
                    priority if (count_reg == mhnr_pkg::COUNT_NONE)
                        state_reg <= S_IDLE;
                    else if (is_clock)
                        state_reg <= (tick_period_reg != '0) ? S_DIV : S_GATE;
                    else if (count_reg != mhnr_pkg::COUNT_FULL)
                        state_reg <= S_IDLE;
                    else if (status_reg[7:4] == mhnr_pkg::KIND_NOTE_ON
                             || status_reg[7:4] == mhnr_pkg::KIND_NOTE_OFF)
                        state_reg <= S_SCAN;
                    else
                        state_reg <= S_LAST;
                end

                S_SCAN:
                begin
                    if (status_reg[7:4] == mhnr_pkg::KIND_NOTE_OFF)
                    begin
                        if (slot_match)
                        begin
                            valid_reg[idx_reg] <= 1'b0;
                            held_count_reg     <= held_count_reg - HC_W'(1);
                        end
                    end
                    else
                    begin
                        if (slot_match)
                            found_reg <= 1'b1;
                        if (!valid_reg[idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                    end
                    if (last_idx)
                        state_reg <= (status_reg[7:4] == mhnr_pkg::KIND_NOTE_OFF)
                                     ? S_IDLE : S_INSERT;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end

                S_INSERT:
                begin
                    if (do_insert)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        held_count_reg          <= count_after_insert;
                    end
                    // a note-on that leaves exactly one note held restarts the clock phase
                    if (count_after_insert == HC_W'(1))
                    begin
                        clock_count_reg    <= '0;
                        retrigger_time_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end

                S_DIV:
                begin
                    if (rem_status.done)
                    begin
                        if (rem_status.zero)
                        begin
                            retrig_reg         <= 1'b1;
                            retrigger_time_reg <= clock_count_reg;
                        end
                        state_reg <= S_GATE;
                    end
                end

                S_GATE:
                begin
                    off_reg <= COUNTER_BITS'(gate_length_reg) <= elapsed;
                    idx_reg <= '0;
                    priority if (retrig_reg)
                        state_reg <= S_ON_WALK;
                    else if (COUNTER_BITS'(gate_length_reg) <= elapsed)
                        state_reg <= S_OFF_WALK;
                    else
                        state_reg <= S_LAST;
                end

                S_ON_WALK, S_OFF_WALK:
                begin
                    if (!valid_reg[idx_reg] || out_free)
                    begin
                        if (valid_reg[idx_reg])
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= {(state_reg == S_ON_WALK)
                                               ? mhnr_pkg::KIND_NOTE_ON
                                               : mhnr_pkg::KIND_NOTE_OFF,
                                               cur_slot.channel};
                            out_first_reg  <= cur_slot.note;
                            out_second_reg <= (state_reg == S_ON_WALK)
                                              ? cur_slot.velocity : '0;
                            out_count_reg  <= mhnr_pkg::COUNT_FULL;
                            out_last_reg   <= 1'b0;
                        end
                        if (last_idx)
                        begin
                            idx_reg <= '0;
                            if (state_reg == S_ON_WALK && off_reg)
                                state_reg <= S_OFF_WALK;
                            else
                                state_reg <= S_LAST;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end

                S_LAST:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_first_reg  <= count_reg[1] ? first_reg : '0;
                        out_second_reg <= (count_reg == mhnr_pkg::COUNT_FULL)
                                          ? second_reg : '0;
                        out_count_reg  <= count_reg;
                        out_last_reg   <= 1'b1;
                        if (is_clock)
                            clock_count_reg <= clock_count_reg + COUNTER_BITS'(1);
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg.ready          = 1'b1;
    assign message.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.out_status  = out_status_reg;
    assign result.out_first   = out_first_reg;
    assign result.out_second  = out_second_reg;
    assign result.out_count   = out_count_reg;
    assign result.last_of_run = out_last_reg;

endmodule

/* hw/rtl/mhnr_rem_unit.sv */
// ----------------------------------------------------------------------------
// mhnr_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mhnr_rem_unit #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [COUNTER_BITS-1:0]             dividend,
    input  logic [mhnr_pkg::DIVISOR_W-1:0]      divisor,
    output mhnr_pkg::rem_status_t               status
);

    localparam int CNT_W = $clog2(COUNTER_BITS + 1);
    localparam int DW    = mhnr_pkg::DIVISOR_W;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [COUNTER_BITS-1:0] dividend_reg;
    logic [DW-1:0]           divisor_reg;
    logic [DW-1:0]           rem_reg;
    logic [DW:0]             trial;
    logic                    fits;

    assign trial = {rem_reg, dividend_reg[COUNTER_BITS-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            dividend_reg <= '0;
            divisor_reg  <= '0;
            rem_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg     <= 1'b1;
                cnt_reg      <= CNT_W'(COUNTER_BITS);
                dividend_reg <= dividend;
                divisor_reg  <= divisor;
                rem_reg      <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg      <= fits ? DW'(trial - {1'b0, divisor_reg}) : trial[DW-1:0];
                dividend_reg <= {dividend_reg[COUNTER_BITS-2:0], 1'b0};
                cnt_reg      <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule
